### design/tilt_gesture_turn_signal_assert.svh
// Assertion macros shared by the tilt gesture turn signal modules
`ifndef TILT_GESTURE_TURN_SIGNAL_ASSERT_SVH
`define TILT_GESTURE_TURN_SIGNAL_ASSERT_SVH

// property must hold at every clock edge outside reset
`define TGTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be true outside reset
`define TGTS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### design/tgts_pkg.sv
// Shared types, constants and the arctangent table of the tilt gesture block
package tgts_pkg;

	localparam int IDX_W      = 5;
	localparam int TABLE_LEN  = 24;
	localparam int SQRT_STEPS = 24;

	localparam logic [1:0]  DIR_NONE   = 2'd0;
	localparam logic [1:0]  DIR_LEFT   = 2'd1;
	localparam logic [1:0]  DIR_RIGHT  = 2'd2;

	localparam logic [14:0] THR_RESET   = 15'd7680;
	localparam logic [22:0] ACC_MAX     = 23'd5898240;
	localparam logic [23:0] ROUND_HALF  = 24'd128;
	localparam logic [14:0] RIGHT_ANGLE = 15'd23040;

	typedef struct packed {
		logic load;
		logic mul;
		logic add;
		logic sqrt_step;
		logic cord_init;
		logic cord_step;
		logic commit;
	} tgts_cmd_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic [22:0] tgts_atan(input logic [IDX_W-1:0] i);
		logic [22:0] v;
		case (i)
			5'd0: v = 23'd2949120;
			5'd1: v = 23'd1740967;
			5'd2: v = 23'd919879;
			5'd3: v = 23'd466945;
			5'd4: v = 23'd234379;
			5'd5: v = 23'd117304;
			5'd6: v = 23'd58666;
			5'd7: v = 23'd29335;
			5'd8: v = 23'd14668;
			5'd9: v = 23'd7334;
			5'd10: v = 23'd3667;
			5'd11: v = 23'd1833;
			5'd12: v = 23'd917;
			5'd13: v = 23'd458;
			5'd14: v = 23'd229;
			5'd15: v = 23'd115;
			5'd16: v = 23'd57;
			5'd17: v = 23'd29;
			5'd18: v = 23'd14;
			5'd19: v = 23'd7;
			5'd20: v = 23'd4;
			5'd21: v = 23'd2;
			5'd22: v = 23'd1;
			default: v = 23'd0;
		endcase
		return v;
	endfunction

endpackage

### design/tgts_if.sv
// Valid/ready channel interfaces for samples and results
interface tgts_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;

	modport source (output valid, mode, accel_x, accel_y, accel_z, input ready);
	modport sink (input valid, mode, accel_x, accel_y, accel_z, output ready);
endinterface

interface tgts_out_if;
	logic               valid;
	logic               ready;
	logic               left_lamp;
	logic               right_lamp;
	logic signed [16:0] adjusted_angle;

	modport source (output valid, left_lamp, right_lamp, adjusted_angle, input ready);
	modport sink (input valid, left_lamp, right_lamp, adjusted_angle, output ready);
endinterface

### design/tgts_ctrl.sv
// Sequencer for the square root, CORDIC and result handshake
module tgts_ctrl
	import tgts_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output tgts_cmd_t        cmd,
	output logic [IDX_W-1:0] idx
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_ADD   = 3'd2;
	localparam logic [2:0] S_SQRT  = 3'd3;
	localparam logic [2:0] S_CINIT = 3'd4;
	localparam logic [2:0] S_CORD  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign idx       = cnt_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = in_valid && in_ready;
		cmd.mul       = (state_q == S_MUL);
		cmd.add       = (state_q == S_ADD);
		cmd.sqrt_step = (state_q == S_SQRT);
		cmd.cord_init = (state_q == S_CINIT);
		cmd.cord_step = (state_q == S_CORD);
		cmd.commit    = (state_q == S_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd.load)
						state_q <= S_MUL;
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					state_q <= S_SQRT;
					cnt_q   <= '0;
				end
				S_SQRT: begin
					if (cnt_q == IDX_W'(SQRT_STEPS - 1)) begin
						state_q <= S_CINIT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_CINIT: state_q <= S_CORD;
				S_CORD: begin
					if (cnt_q == IDX_W'(CORDIC_STEPS - 1)) begin
						state_q <= S_DONE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "tilt_gesture_turn_signal_assert.svh"

	`TGTS_NEVER(a_commit_blocked, cmd.commit && out_valid_q && !out_ready, "commit over held result")
	`TGTS_ASSERT(a_load_starts, cmd.load |=> state_q == S_MUL, "accepted sample did not start")
	`TGTS_NEVER(a_cord_range, state_q == S_CORD && cnt_q >= IDX_W'(CORDIC_STEPS), "CORDIC index overrun")
	`TGTS_ASSERT(a_commit_shows, cmd.commit |=> out_valid_q, "commit without result valid")

endmodule

### design/tgts_dp.sv
// Datapath: squares, digit-by-digit root, vectoring CORDIC and gesture state
module tgts_dp
	import tgts_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  tgts_cmd_t          cmd,
	input  logic [IDX_W-1:0]   idx,
	input  logic               cfg_we,
	input  logic [14:0]        cfg_wdata,
	input  logic               in_mode,
	input  logic signed [15:0] in_x,
	input  logic signed [15:0] in_y,
	input  logic signed [15:0] in_z,
	output logic               left_lamp,
	output logic               right_lamp,
	output logic signed [16:0] adjusted_angle
);

	logic               mode_q;
	logic               neg_q;
	logic [16:0]        mx_q;
	logic signed [15:0] ay_q;
	logic signed [15:0] az_q;
	logic [30:0]        ysq_q;
	logic [30:0]        zsq_q;
	logic [47:0]        rad_q;
	logic [25:0]        rem_q;
	logic [23:0]        root_q;
	logic signed [26:0] vx_q;
	logic signed [26:0] vy_q;
	logic signed [24:0] acc_q;
	logic [1:0]         dir_q;
	logic               pm_q;
	logic signed [15:0] offset_q;
	logic [14:0]        thr_q;
	logic signed [16:0] adj_q;

	logic signed [16:0] x_ext;
	logic signed [16:0] x_neg;
	logic signed [31:0] ysq;
	logic signed [31:0] zsq;
	logic [31:0]        sq_sum;
	logic [27:0]        rem_sh;
	logic [27:0]        trial;
	logic               take;
	logic [27:0]        rem_sub;
	logic signed [26:0] vx_sh;
	logic signed [26:0] vy_sh;
	logic signed [24:0] atan_ext;
	logic [22:0]        acc_cl;
	logic [23:0]        rnd_sum;
	logic [14:0]        mag;
	logic signed [15:0] mag_s;
	logic signed [15:0] pitch;
	logic signed [16:0] adj;
	logic signed [17:0] adj_w;
	logic signed [17:0] thr_w;
	logic               above;
	logic               below;

	assign x_ext = {in_x[15], in_x};
	assign x_neg = -x_ext;
	assign ysq   = ay_q * ay_q;
	assign zsq   = az_q * az_q;
	assign sq_sum = {1'b0, ysq_q} + {1'b0, zsq_q};

	assign rem_sh  = {rem_q, rad_q[47:46]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign take    = (rem_sh >= trial);
	assign rem_sub = rem_sh - trial;

	assign vx_sh    = vx_q >>> idx;
	assign vy_sh    = vy_q >>> idx;
	assign atan_ext = signed'({2'b00, tgts_atan(idx)});

	always_comb begin
		if (acc_q[24])
			acc_cl = '0;
		else if (acc_q[23:0] > {1'b0, ACC_MAX})
			acc_cl = ACC_MAX;
		else
			acc_cl = acc_q[22:0];
		rnd_sum = {1'b0, acc_cl} + ROUND_HALF;
		if (mx_q == '0)
			mag = '0;
		else if (root_q == '0)
			mag = RIGHT_ANGLE;
		else
			mag = rnd_sum[22:8];
		mag_s = signed'({1'b0, mag});
		pitch = neg_q ? -mag_s : mag_s;
		adj   = {pitch[15], pitch} - {offset_q[15], offset_q};
		adj_w = {adj[16], adj};
		thr_w = signed'({3'b000, thr_q});
		above = (adj_w > thr_w);
		below = (adj_w < -thr_w);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			neg_q  <= in_x[15];
			mx_q   <= in_x[15] ? x_neg : x_ext;
			ay_q   <= in_y;
			az_q   <= in_z;
		end
		if (cmd.mul) begin
			ysq_q <= ysq[30:0];
			zsq_q <= zsq[30:0];
		end
		if (cmd.add) begin
			rad_q  <= {sq_sum[31:0], 16'h0000};
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.sqrt_step) begin
			rad_q <= {rad_q[45:0], 2'b00};
			if (take) begin
				rem_q  <= rem_sub[25:0];
				root_q <= {root_q[22:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[25:0];
				root_q <= {root_q[22:0], 1'b0};
			end
		end
		if (cmd.cord_init) begin
			vx_q  <= signed'({3'b000, root_q});
			vy_q  <= signed'({2'b00, mx_q, 8'h00});
			acc_q <= '0;
		end
		if (cmd.cord_step) begin
			if (vy_q > 27'sd0) begin
				vx_q  <= vx_q + vy_sh;
				vy_q  <= vy_q - vx_sh;
				acc_q <= acc_q + atan_ext;
			end else begin
				vx_q  <= vx_q - vy_sh;
				vy_q  <= vy_q + vx_sh;
				acc_q <= acc_q - atan_ext;
			end
		end
		if (cmd.commit)
			adj_q <= mode_q ? '0 : adj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= DIR_NONE;
			pm_q     <= 1'b0;
			offset_q <= '0;
			thr_q    <= THR_RESET;
		end else begin
			if (cfg_we)
				thr_q <= cfg_wdata;
			if (cmd.commit) begin
				if (mode_q) begin
					offset_q <= pitch;
				end else if (above) begin
					if (pm_q && dir_q == DIR_LEFT) begin
						dir_q <= DIR_NONE;
						pm_q  <= 1'b0;
					end else if (pm_q && dir_q == DIR_NONE) begin
						dir_q <= DIR_LEFT;
						pm_q  <= 1'b0;
					end
				end else if (below) begin
					if (pm_q && dir_q == DIR_RIGHT) begin
						dir_q <= DIR_NONE;
						pm_q  <= 1'b0;
					end else if (pm_q && dir_q == DIR_NONE) begin
						dir_q <= DIR_RIGHT;
						pm_q  <= 1'b0;
					end
				end else begin
					pm_q <= 1'b1;
				end
			end
		end
	end

	assign left_lamp      = (dir_q == DIR_LEFT);
	assign right_lamp     = (dir_q == DIR_RIGHT);
	assign adjusted_angle = adj_q;

	`include "tilt_gesture_turn_signal_assert.svh"

	`TGTS_ASSERT(a_cal_zero, cmd.commit && mode_q |=> adj_q == 17'sd0, "calibrate result not zero")

endmodule

### design/tilt_gesture_turn_signal.sv
// A sample accepted in idle passes through the square, sum, square root, CORDIC init and CORDIC
// iteration states to the commit; no new sample is taken until the previous one is committed.
// The one-bit-per-cycle square root is followed by the shared CORDIC iteration.
// A new sample is taken while the previous result still waits on the output register.
// Reset: asynchronous, clears lamps, middle-band flag and offset; threshold returns to 7680.
module tilt_gesture_turn_signal
	import tgts_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [14:0] cfg_wdata,
	tgts_in_if.sink     sample,
	tgts_out_if.source  result
);

	tgts_cmd_t        cmd;
	logic [IDX_W-1:0] idx;

	tgts_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.cmd      (cmd),
		.idx      (idx)
	);

	tgts_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.idx           (idx),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_mode       (sample.mode),
		.in_x          (sample.accel_x),
		.in_y          (sample.accel_y),
		.in_z          (sample.accel_z),
		.left_lamp     (result.left_lamp),
		.right_lamp    (result.right_lamp),
		.adjusted_angle(result.adjusted_angle)
	);

endmodule

### sim/tgts_lamp_checker.sv
// Checker for the tilt gesture block: predicts lamp states and adjusted pitch, compares results
`timescale 1ns / 100ps
module tgts_lamp_checker
	import tgts_pkg::*;
#(
	parameter int STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [14:0] cfg_wdata,
	tgts_in_if          sample,
	tgts_out_if         result,
	output int          mismatch_count,
	output int          reports_waiting
);

	typedef struct packed {
		logic               left_lamp;
		logic               right_lamp;
		logic signed [16:0] adjusted_angle;
	} lamp_report_t;

	longint atan_fine_tbl [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	lamp_report_t       expected_reports [$];
	logic [14:0]        threshold;
	logic [1:0]         direction;
	logic               passed_mid;
	logic signed [15:0] offset;

	initial mismatch_count = 0;

	function automatic longint unsigned sqrt_floor(input longint unsigned v);
		longint unsigned root;
		longint unsigned probe;
		root  = 0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= root + probe) begin
				v    = v - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic logic signed [15:0] predict_pitch(input logic signed [15:0] ax,
			input logic signed [15:0] ay, input logic signed [15:0] az);
		longint          mx;
		longint          vx;
		longint          vy;
		longint          nx;
		longint          ny;
		longint          acc;
		longint unsigned sq;
		int              res;
		mx  = (ax < 0) ? -longint'(ax) : longint'(ax);
		sq  = longint'(ay) * longint'(ay) + longint'(az) * longint'(az);
		vx  = longint'(sqrt_floor(sq << 16));
		vy  = mx * 256;
		acc = 0;
		if (mx == 0)
			return 16'sd0;
		if (vx == 0) begin
			res = 23040;
		end else begin
			for (int i = 0; i < STEPS && i < 24; i++) begin
				if (vy > 0) begin
					nx  = vx + (vy >>> i);
					ny  = vy - (vx >>> i);
					acc = acc + atan_fine_tbl[i];
				end else begin
					nx  = vx - (vy >>> i);
					ny  = vy + (vx >>> i);
					acc = acc - atan_fine_tbl[i];
				end
				vx = nx;
				vy = ny;
			end
			if (acc < 0)
				acc = 0;
			if (acc > longint'(ACC_MAX))
				acc = longint'(ACC_MAX);
			res = int'((acc + 128) >>> 8);
		end
		return (ax < 0) ? 16'(-res) : 16'(res);
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		if (mismatch_count < 200)
			$display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lamp_report_t       want;
		lamp_report_t       fresh;
		logic signed [15:0] pitch;
		logic signed [16:0] adj;
		logic signed [16:0] thr_s;
		logic [1:0]         dir_n;
		logic               mid_n;
		if (!arst_n) begin
			threshold  <= THR_RESET;
			direction  <= DIR_NONE;
			passed_mid <= 1'b0;
			offset     <= '0;
			expected_reports.delete();
			reports_waiting <= 0;
		end else begin
			if (cfg_we)
				threshold <= cfg_wdata;
			if (result.valid && result.ready) begin
				if (expected_reports.size() == 0) begin
					flag_mismatch("unexpected result", longint'(result.adjusted_angle), 0);
				end else begin
					want = expected_reports.pop_front();
					if (result.left_lamp !== want.left_lamp)
						flag_mismatch("left_lamp", longint'(result.left_lamp),
							longint'(want.left_lamp));
					if (result.right_lamp !== want.right_lamp)
						flag_mismatch("right_lamp", longint'(result.right_lamp),
							longint'(want.right_lamp));
					if (result.adjusted_angle !== want.adjusted_angle)
						flag_mismatch("adjusted_angle", longint'(result.adjusted_angle),
							longint'(want.adjusted_angle));
				end
			end
			if (sample.valid && sample.ready) begin
				pitch = predict_pitch(sample.accel_x, sample.accel_y, sample.accel_z);
				dir_n = direction;
				mid_n = passed_mid;
				adj   = '0;
				thr_s = {2'b00, threshold};
				if (sample.mode) begin
					offset <= pitch;
				end else begin
					adj = pitch - offset;
					if (adj > thr_s) begin
						if (mid_n) begin
							if (dir_n == DIR_LEFT) begin
								dir_n = DIR_NONE;
								mid_n = 1'b0;
							end else if (dir_n == DIR_NONE) begin
								dir_n = DIR_LEFT;
								mid_n = 1'b0;
							end
						end
					end else if (adj < -thr_s) begin
						if (mid_n) begin
							if (dir_n == DIR_RIGHT) begin
								dir_n = DIR_NONE;
								mid_n = 1'b0;
							end else if (dir_n == DIR_NONE) begin
								dir_n = DIR_RIGHT;
								mid_n = 1'b0;
							end
						end
					end else begin
						mid_n = 1'b1;
					end
				end
				direction  <= dir_n;
				passed_mid <= mid_n;
				fresh.left_lamp      = (dir_n == DIR_LEFT);
				fresh.right_lamp     = (dir_n == DIR_RIGHT);
				fresh.adjusted_angle = adj;
				expected_reports.push_back(fresh);
			end
			reports_waiting <= expected_reports.size();
		end
	end

endmodule

### sim/tb.sv
// Testbench top: drives samples, threshold writes and result back-pressure, gives the verdict
`timescale 1ns / 100ps
module tb
	import tgts_pkg::*;
();

	localparam int STEPS       = 16;
	localparam int SETTLE      = STEPS + 40;
	localparam int PER_SETTING = 220;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [14:0] cfg_wdata;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          mismatches;
	int          waiting;
	logic [14:0] thr_plan [8];

	tgts_in_if  sample_ch ();
	tgts_out_if result_ch ();

	tilt_gesture_turn_signal #(
		.CORDIC_STEPS(STEPS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.sample   (sample_ch),
		.result   (result_ch)
	);

	tgts_lamp_checker #(
		.STEPS(STEPS)
	) lamp_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.sample         (sample_ch),
		.result         (result_ch),
		.mismatch_count (mismatches),
		.reports_waiting(waiting)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic signed [15:0] spread_axis();
		logic signed [15:0] v;
		case ($urandom_range(9))
			0: v = 16'sh8000;
			1: v = 16'sh7fff;
			2: v = 16'sd0;
			3: v = -16'sd1;
			default: begin
				v = 16'($urandom);
				v = v >>> $urandom_range(15);
			end
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] signed_span(input int unsigned lo, input int unsigned hi);
		logic signed [15:0] v;
		v = 16'($urandom_range(hi, lo));
		return $urandom_range(1) ? -v : v;
	endfunction

	task automatic send_sample(input logic m, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic signed [15:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid   <= 1'b0;
			sample_ch.mode    <= 1'($urandom);
			sample_ch.accel_x <= 16'($urandom);
			sample_ch.accel_y <= 16'($urandom);
			sample_ch.accel_z <= 16'($urandom);
			@(posedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.mode    <= m;
		sample_ch.accel_x <= x;
		sample_ch.accel_y <= y;
		sample_ch.accel_z <= z;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	task automatic send_random_item();
		int unsigned        pick;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		pick = $urandom_range(99);
		x = spread_axis();
		y = spread_axis();
		z = spread_axis();
		if (pick < 30) begin
			x = signed_span(0, 1500);
			z = signed_span(8192, 32767);
			send_sample(1'b0, x, y, z);
		end else if (pick < 50) begin
			x = 16'($urandom_range(32767, 12000));
			send_sample(1'b0, x, y >>> 3, z >>> 3);
		end else if (pick < 70) begin
			x = -16'($urandom_range(32767, 12000));
			send_sample(1'b0, x, y >>> 3, z >>> 3);
		end else if (pick < 90) begin
			send_sample(1'b0, x, y, z);
		end else if (pick < 97) begin
			x = signed_span(0, 2000);
			z = signed_span(8192, 32767);
			send_sample(1'b1, x, y, z);
		end else begin
			send_sample(1'b1, x, y, z);
		end
	endtask

	task automatic settle_idle();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [14:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int n;
		int ph;
		int s;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		sample_ch.valid   = 1'b0;
		sample_ch.mode    = 1'b0;
		sample_ch.accel_x = '0;
		sample_ch.accel_y = '0;
		sample_ch.accel_z = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		send_sample(1'b0, 16'sd0, 16'sd0, 16'sd0);
		send_sample(1'b0, 16'sh7fff, 16'sd0, 16'sd0);
		send_sample(1'b0, 16'sd0, 16'sd100, -16'sd50);
		send_sample(1'b0, 16'sh8000, 16'sd0, 16'sd0);
		send_sample(1'b0, 16'sh7fff, 16'sh8000, 16'sh8000);
		send_sample(1'b0, 16'sh7fff, 16'sd0, 16'sd0);
		send_sample(1'b0, 16'sd5, 16'sd0, 16'sd1000);
		send_sample(1'b0, 16'sh8000, 16'sh7fff, 16'sh7fff);
		send_sample(1'b1, 16'sd16384, 16'sd0, 16'sd16384);
		send_sample(1'b0, 16'sd16384, 16'sd0, 16'sd16384);
		send_sample(1'b0, -16'sd1, 16'sd0, 16'sd0);
		send_sample(1'b0, 16'sd1, 16'sh8000, 16'sh7fff);
		send_sample(1'b0, 16'sh7fff, 16'sh7fff, 16'sd0);
		send_sample(1'b1, 16'sd0, 16'sd0, 16'sd0);
		send_sample(1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
		send_sample(1'b1, 16'sh8000, 16'sd0, 16'sd0);
		send_sample(1'b0, 16'sh7fff, 16'sd0, 16'sd0);
		send_sample(1'b1, 16'sh7fff, 16'sd0, 16'sd0);
		send_sample(1'b0, 16'sh8000, 16'sd0, 16'sd0);
		send_sample(1'b1, 16'sd0, 16'sd0, 16'sd0);
		settle_idle();
		write_threshold(15'd0);
		send_sample(1'b0, 16'sd0, 16'sd1, 16'sd1);
		send_sample(1'b0, 16'sd200, 16'sd0, 16'sh7fff);
		settle_idle();
		write_threshold(RIGHT_ANGLE);
		send_sample(1'b0, 16'sh7fff, 16'sd0, 16'sd0);
		send_sample(1'b0, 16'sh8000, 16'sd0, 16'sd0);

		thr_plan[0] = THR_RESET;
		thr_plan[1] = 15'd0;
		thr_plan[2] = RIGHT_ANGLE;
		thr_plan[3] = 15'($urandom_range(23040, 0));
		thr_plan[4] = 15'd1;
		thr_plan[5] = 15'($urandom_range(23040, 0));
		thr_plan[6] = 15'd22000;
		thr_plan[7] = 15'($urandom_range(23040, 0));

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 70;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 70;
				end
				default: begin
					send_idle_pct  = 12;
					recv_stall_pct = 12;
				end
			endcase
			for (s = 0; s < 2; s++) begin
				settle_idle();
				write_threshold(thr_plan[ph * 2 + s]);
				for (n = 0; n < PER_SETTING; n++)
					send_random_item();
			end
		end

		settle_idle();
		if (mismatches == 0 && waiting == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### tilt_gesture_turn_signal.f
+incdir+design
design/tgts_pkg.sv
design/tgts_if.sv
design/tgts_ctrl.sv
design/tgts_dp.sv
design/tilt_gesture_turn_signal.sv
sim/tgts_lamp_checker.sv
sim/tb.sv
